[hw/rtl/stack_with_pop_minimum_top_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the stack with pop-minimum
// Clocked assertion helpers used by the checker of the stack block.
// ----------------------------------------------------------------------------
`ifndef STACK_WITH_POP_MINIMUM_TOP_MACROS_SVH
`define STACK_WITH_POP_MINIMUM_TOP_MACROS_SVH

// Checks a property on every rising edge of clk, with reset held off.
`define SWPM_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Same check with a standard message.
`define SWPM_CHECK(lbl, prop) \
    `SWPM_ASSERT(lbl, prop, "stack check failed")

`endif

[hw/rtl/swpm_pkg.sv]
// ----------------------------------------------------------------------------
// Stack with pop-minimum: shared package
// Types, codes and constants shared by the cell chain, top level and checker.
// ----------------------------------------------------------------------------
package swpm_pkg;

    localparam int DEPTH     = 16;
    localparam int CNT_W     = $clog2(DEPTH + 1);
    localparam int DATA_W    = 32;
    localparam int OUT_CNT_W = 5;

    typedef logic signed [DATA_W-1:0] data_t;
    typedef logic [CNT_W-1:0]         count_t;

    typedef enum logic [1:0] {
        OP_PUSH = 2'd0,
        OP_POP  = 2'd1,
        OP_TOP  = 2'd2,
        OP_XMIN = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2,
        ST_NULL  = 2'd3
    } status_t;

    // What every cell does in a cycle.
    typedef enum logic [1:0] {
        CMD_HOLD = 2'd0,
        CMD_PUSH = 2'd1,
        CMD_POP  = 2'd2,
        CMD_XMIN = 2'd3
    } cell_cmd_t;

    typedef struct packed {
        cell_cmd_t cmd;
        data_t     gmin;
    } cell_ctl_t;

    // Data that travels between neighboring cells.
    typedef struct packed {
        data_t entry;
        data_t run_min;
    } cell_link_t;

    localparam data_t NULL_RESET = -32'sd11111;

    function automatic data_t min2(data_t a, data_t b);
        return (a < b) ? a : b;
    endfunction

endpackage

[hw/rtl/stack_with_pop_minimum_top.sv]
// ----------------------------------------------------------------------------
// Stack with pop-minimum: top level
// Bounded LIFO stack of signed 32-bit values with push, pop, read top and
// pop-minimum, built as a chain of cells with the top of stack in cell 0.
// ----------------------------------------------------------------------------
//
//  Channel   Handshake              Beat contents
//  -------   --------------------   ------------------------------------------
//  in        in_valid / in_ready    op, push_value
//  out       out_valid / out_ready  result_value, status, is_empty, entry_count
//  cfg       cfg_valid / cfg_ready  cfg_data (null value register)
//
// Push, pop and read top need no repair. Pop-minimum is followed by a repair:
// a repair token starts just above the removed entry and climbs
// one cell per cycle to rebuild the running minimums above the gap.
// A result sits in the output register; a new beat is taken once the
// repair is done and that register is empty or being drained.
// Reset empties the stack and loads the null value with -11111; the entry
// storage itself needs no clearing since only occupied cells are ever read.
//
module stack_with_pop_minimum_top
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  swpm_pkg::op_t           op,
    input  logic signed [31:0]      push_value,
    output logic                    out_valid,
    input  logic                    out_ready,
    output logic signed [31:0]      result_value,
    output swpm_pkg::status_t       status,
    output logic                    is_empty,
    output logic [4:0]              entry_count,
    input  logic                    cfg_valid,
    output logic                    cfg_ready,
    input  logic signed [31:0]      cfg_data
);
    import swpm_pkg::*;

    // Control state.
    count_t  count_reg;
    count_t  count_next;
    data_t   null_reg;
    logic    out_valid_reg;

    // Output payload registers.
    data_t   res_reg;
    status_t status_reg;
    count_t  cnt_out_reg;

    logic      accept;
    logic      busy;
    cell_cmd_t cmd;
    data_t     res;
    status_t   st;
    cell_ctl_t ctl;

    // Links between cells; index DEPTH is the empty space below the bottom.
    cell_link_t      link_w  [DEPTH+1];
    logic [DEPTH:0]  occ_w;
    logic [DEPTH:0]  match_w;
    logic [DEPTH:0]  tok_w;
    logic [DEPTH:0]  above_w;
    cell_link_t      push_link;

    // A pop-minimum repair token anywhere in the chain holds off new beats.
    assign busy     = |tok_w[DEPTH-1:0];
    assign in_ready = !busy && (!out_valid_reg || out_ready);
    assign accept   = in_valid && in_ready;
    assign cfg_ready = 1'b1;

    // Cell 0 holds the top; its running minimum is the minimum of the stack.
    assign ctl.cmd  = cmd;
    assign ctl.gmin = link_w[0].run_min;

    // A new top's running minimum folds in the old one when the stack is not empty.
    assign push_link.entry   = push_value;
    assign push_link.run_min = occ_w[0] ? min2(push_value, link_w[0].run_min) : push_value;

    assign link_w[DEPTH].entry   = '0;
    assign link_w[DEPTH].run_min = '0;
    assign occ_w[DEPTH]   = 1'b0;
    assign match_w[DEPTH] = 1'b0;
    assign tok_w[DEPTH]   = 1'b0;
    assign above_w[0]     = 1'b0;

    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        assign occ_w[i] = (count_reg > count_t'(i));

        if (i == 0)
        begin : g_top
            swpm_cell u_cell
            (
                .clk       (clk),
                .rst_n     (rst_n),
                .ctl       (ctl),
                .occ       (occ_w[i]),
                .up_link   (push_link),
                .dn_link   (link_w[i+1]),
                .dn_occ    (occ_w[i+1]),
                .dn_match  (match_w[i+1]),
                .dn_tok    (tok_w[i+1]),
                .above_in  (above_w[i]),
                .link      (link_w[i]),
                .match     (match_w[i]),
                .above_out (above_w[i+1]),
                .tok       (tok_w[i])
            );
        end
        else
        begin : g_rest
            swpm_cell u_cell
            (
                .clk       (clk),
                .rst_n     (rst_n),
                .ctl       (ctl),
                .occ       (occ_w[i]),
                .up_link   (link_w[i-1]),
                .dn_link   (link_w[i+1]),
                .dn_occ    (occ_w[i+1]),
                .dn_match  (match_w[i+1]),
                .dn_tok    (tok_w[i+1]),
                .above_in  (above_w[i]),
                .link      (link_w[i]),
                .match     (match_w[i]),
                .above_out (above_w[i+1]),
                .tok       (tok_w[i])
            );
        end
    end

    // Operation decode. The null check comes ahead of the full check, and
    // every error leaves the stack untouched with a zero result.
    always_comb
    begin
        cmd        = CMD_HOLD;
        res        = '0;
        st         = ST_OK;
        count_next = count_reg;
        case (op)
            OP_PUSH:
            begin
                if (push_value == null_reg)
                begin
                    st = ST_NULL;
                end
                else if (count_reg == count_t'(DEPTH))
                begin
                    st = ST_FULL;
                end
                else
                begin
                    cmd        = CMD_PUSH;
                    count_next = count_reg + count_t'(1);
                end
            end
            OP_POP:
            begin
                if (!occ_w[0])
                begin
                    st = ST_EMPTY;
                end
                else
                begin
                    cmd        = CMD_POP;
                    res        = link_w[0].entry;
                    count_next = count_reg - count_t'(1);
                end
            end
            OP_TOP:
            begin
                if (!occ_w[0])
                begin
                    st = ST_EMPTY;
                end
                else
                begin
                    res = link_w[0].entry;
                end
            end
            OP_XMIN:
            begin
                if (!occ_w[0])
                begin
                    st = ST_EMPTY;
                end
                else
                begin
                    cmd        = CMD_XMIN;
                    res        = link_w[0].run_min;
                    count_next = count_reg - count_t'(1);
                end
            end
            default:
            begin
                st = ST_OK;
            end
        endcase
        // Without a beat the cells only keep their running minimums current.
        if (!accept)
        begin
            cmd        = CMD_HOLD;
            count_next = count_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            null_reg      <= NULL_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            if (cfg_valid && cfg_ready)
            begin
                null_reg <= cfg_data;
            end
            if (accept)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            res_reg     <= res;
            status_reg  <= st;
            cnt_out_reg <= count_next;
        end
    end

    assign out_valid    = out_valid_reg;
    assign result_value = res_reg;
    assign status       = status_reg;
    assign is_empty     = (cnt_out_reg == '0);
    assign entry_count  = OUT_CNT_W'(cnt_out_reg);

endmodule

[hw/rtl/swpm_cell.sv]
// ----------------------------------------------------------------------------
// Stack cell
// Holds one stack entry and the minimum of it and every entry below it.
// ----------------------------------------------------------------------------
module swpm_cell
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  swpm_pkg::cell_ctl_t  ctl,
    input  logic                 occ,
    input  swpm_pkg::cell_link_t up_link,
    input  swpm_pkg::cell_link_t dn_link,
    input  logic                 dn_occ,
    input  logic                 dn_match,
    input  logic                 dn_tok,
    input  logic                 above_in,
    output swpm_pkg::cell_link_t link,
    output logic                 match,
    output logic                 above_out,
    output logic                 tok
);
    import swpm_pkg::*;

    data_t entry_reg;
    data_t entry_next;
    data_t min_reg;
    data_t min_next;
    logic  tok_reg;
    logic  tok_next;
    data_t fix_min;

    // The topmost occupied cell equal to the global minimum is the one removed.
    assign match     = occ && (entry_reg == ctl.gmin);
    assign above_out = above_in | match;

    // Running minimum rebuilt from the cell below.
    assign fix_min = dn_occ ? min2(entry_reg, dn_link.run_min) : entry_reg;

    always_comb
    begin
        entry_next = entry_reg;
        min_next   = fix_min;
        case (ctl.cmd)
            CMD_PUSH:
            begin
                entry_next = up_link.entry;
                min_next   = up_link.run_min;
            end
            CMD_POP:
            begin
                entry_next = dn_link.entry;
                min_next   = dn_link.run_min;
            end
            CMD_XMIN:
            begin
                if (above_out)
                begin
                    entry_next = dn_link.entry;
                    min_next   = dn_link.run_min;
                end
            end
            default:
            begin
                entry_next = entry_reg;
                min_next   = fix_min;
            end
        endcase
        // A repair token starts just above the removed cell and climbs one
        // cell a cycle toward the top.
        tok_next = (ctl.cmd == CMD_XMIN) ? (dn_match && !above_out) : dn_tok;
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
        min_reg   <= min_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tok_reg <= 1'b0;
        end
        else
        begin
            tok_reg <= tok_next;
        end
    end

    assign link.entry   = entry_reg;
    assign link.run_min = min_reg;
    assign tok          = tok_reg;

endmodule

[hw/rtl/swpm_checker.sv]
// ----------------------------------------------------------------------------
// Stack with pop-minimum: port checker
// Watches the top-level ports and checks result beats over time.
// ----------------------------------------------------------------------------
`include "stack_with_pop_minimum_top_macros.svh"

module swpm_checker
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    input  logic                    in_ready,
    input  logic                    out_valid,
    input  logic                    out_ready,
    input  logic signed [31:0]      result_value,
    input  swpm_pkg::status_t       status,
    input  logic                    is_empty,
    input  logic [4:0]              entry_count
);
    import swpm_pkg::*;

    // A result beat that is not taken stays put.
    `SWPM_CHECK(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(result_value))

    // The empty flag agrees with the count.
    `SWPM_CHECK(a_empty_flag, out_valid |-> (is_empty == (entry_count == 5'd0)))

    // The count never goes past the depth.
    `SWPM_CHECK(a_count_range, out_valid |-> (entry_count <= 5'(DEPTH)))

    // Every error beat carries a zero value.
    `SWPM_ASSERT(a_err_zero, out_valid && (status != ST_OK) |-> (result_value == 32'sd0), "error beat with nonzero value")

    // An accepted beat shows up as a result in the next cycle.
    `SWPM_CHECK(a_in_to_out, in_valid && in_ready |=> out_valid)

endmodule

bind stack_with_pop_minimum_top swpm_checker u_swpm_checker (.*);
